[design/bpc_pkg.sv]
// ----------------------------------------------------------------------------
// bpc_pkg
// Types and constants for the button press classifier.
// ----------------------------------------------------------------------------
`default_nettype none

package bpc_pkg;

  typedef struct packed {
    logic        opcode;
    logic [31:0] now_ms;
    logic        raw_pressed;
    logic [15:0] pin_mask;
  } in_item_t;

  typedef struct packed {
    logic [1:0] event_code;
    logic       pressed;
    logic       haptic_play;
    logic [7:0] haptic_wave;
    logic [1:0] fsm_state;
  } out_item_t;

  typedef enum logic [3:0] {
    PH_IDLE    = 4'b0001,
    PH_DOWN    = 4'b0010,
    PH_PRESSED = 4'b0100,
    PH_UP      = 4'b1000
  } phase_t;

  localparam logic OP_TICK = 1'b0;
  localparam logic OP_EDGE = 1'b1;

  localparam logic [15:0] BUTTON_PIN = 16'h0020;

  localparam logic [1:0] EV_NONE   = 2'd0;
  localparam logic [1:0] EV_SINGLE = 2'd1;
  localparam logic [1:0] EV_LONG   = 2'd2;

  localparam logic [1:0] FSM_IDLE    = 2'd0;
  localparam logic [1:0] FSM_DOWN    = 2'd1;
  localparam logic [1:0] FSM_PRESSED = 2'd2;
  localparam logic [1:0] FSM_UP      = 2'd3;

  localparam logic [2:0] REG_DEBOUNCE      = 3'd0;
  localparam logic [2:0] REG_LONG_PRESS    = 3'd1;
  localparam logic [2:0] REG_SINGLE_MAX    = 3'd2;
  localparam logic [2:0] REG_RELEASE_DELAY = 3'd3;
  localparam logic [2:0] REG_LOCKOUT       = 3'd4;
  localparam logic [2:0] REG_WAVE_PLAY     = 3'd5;
  localparam logic [2:0] REG_PRESS_WAVE    = 3'd6;
  localparam logic [2:0] REG_RELEASE_WAVE  = 3'd7;

  localparam logic [15:0] RST_DEBOUNCE      = 16'd50;
  localparam logic [15:0] RST_LONG_PRESS    = 16'd1000;
  localparam logic [15:0] RST_SINGLE_MAX    = 16'd500;
  localparam logic [15:0] RST_RELEASE_DELAY = 16'd60;
  localparam logic [15:0] RST_LOCKOUT       = 16'd70;
  localparam logic [15:0] RST_WAVE_PLAY     = 16'd50;
  localparam logic [7:0]  RST_PRESS_WAVE    = 8'd26;
  localparam logic [7:0]  RST_RELEASE_WAVE  = 8'd6;

endpackage

`default_nettype wire

[design/button_press_classifier.sv]
// ----------------------------------------------------------------------------
// button_press_classifier
// Debounce, single/long press detection and haptic waveform requests.
// ----------------------------------------------------------------------------
// Pipeline: input register, then result register; state is updated as an
// item enters the result stage.
// Throughput: one item per cycle while out_ready does not stall the output.
// Reset: synchronous; restores register defaults, idle phase, empty pipeline.
`default_nettype none

module button_press_classifier import bpc_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire in_item_t  in_data,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_item_t      out_data,
  input  wire logic        cfg_write,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  logic [15:0] debounce_ms, long_press_ms, single_max_ms, release_min_delay_ms;
  logic [15:0] lockout_ms, waveform_play_ms;
  logic [7:0]  press_wave_id, release_wave_id;

  phase_t      phase, phase_next;
  logic [31:0] phase_since, phase_since_next;
  logic [31:0] press_start, press_start_next;
  logic [31:0] release_due, release_due_next;
  logic [31:0] lockout_until, lockout_until_next;
  logic [31:0] press_wave_end, press_wave_end_next;
  logic        held, held_next;
  logic        long_done, long_done_next;
  logic        press_wave_played, press_wave_played_next;
  logic        release_pending, release_pending_next;
  logic        release_wave_played, release_wave_played_next;

  logic      s1_valid;
  in_item_t  s1_item;
  logic      s1_advance, s1_fire;
  out_item_t result;

  logic [31:0] in_phase, press_dur, press_age, earliest;
  logic        single_ok;

  assign s1_advance = !out_valid || out_ready;
  assign s1_fire    = s1_valid && s1_advance;
  assign in_ready   = !s1_valid || s1_advance;

  assign in_phase  = s1_item.now_ms - phase_since;
  assign press_dur = s1_item.now_ms - press_start;
  assign single_ok = (press_dur >= {16'd0, debounce_ms})
                  && (press_dur < {16'd0, long_press_ms})
                  && (press_dur < {16'd0, single_max_ms});
  assign earliest  = press_start + {16'd0, release_min_delay_ms};

  always_comb begin
    phase_next               = phase;
    phase_since_next         = phase_since;
    press_start_next         = press_start;
    release_due_next         = release_due;
    lockout_until_next       = lockout_until;
    press_wave_end_next      = press_wave_end;
    held_next                = held;
    long_done_next           = long_done;
    press_wave_played_next   = press_wave_played;
    release_pending_next     = release_pending;
    release_wave_played_next = release_wave_played;
    press_age                = 32'd0;
    result                   = '0;
    result.event_code        = EV_NONE;

    if (s1_item.opcode == OP_TICK) begin
      case (phase)
        PH_IDLE: begin
          if (s1_item.raw_pressed) begin
            phase_next       = PH_DOWN;
            phase_since_next = s1_item.now_ms;
            long_done_next   = 1'b0;
          end
        end
        PH_DOWN: begin
          if (!s1_item.raw_pressed) begin
            phase_next       = PH_IDLE;
            phase_since_next = s1_item.now_ms;
          end else if (in_phase >= {16'd0, debounce_ms}) begin
            phase_next       = PH_PRESSED;
            phase_since_next = s1_item.now_ms;
            held_next        = 1'b1;
            press_start_next = s1_item.now_ms;
          end
        end
        PH_PRESSED: begin
          if (!s1_item.raw_pressed) begin
            phase_next       = PH_UP;
            phase_since_next = s1_item.now_ms;
          end
        end
        PH_UP: begin
          if (s1_item.raw_pressed) begin
            phase_next       = PH_PRESSED;
            phase_since_next = s1_item.now_ms;
          end else if (in_phase >= {16'd0, debounce_ms}) begin
            phase_next       = PH_IDLE;
            phase_since_next = s1_item.now_ms;
            held_next        = 1'b0;
            if (single_ok && !long_done) result.event_code = EV_SINGLE;
          end
        end
        default: begin
          phase_next = PH_IDLE;
        end
      endcase

      press_age = s1_item.now_ms - press_start_next;
      if (held_next && !long_done_next && press_age >= {16'd0, long_press_ms}) begin
        long_done_next    = 1'b1;
        result.event_code = EV_LONG;
      end

      if (release_pending && s1_item.now_ms >= release_due && !release_wave_played) begin
        if (!held_next && s1_item.now_ms >= press_wave_end) begin
          result.haptic_play       = 1'b1;
          result.haptic_wave       = release_wave_id;
          release_wave_played_next = 1'b1;
        end
        release_pending_next = 1'b0;
      end
    end else if (s1_item.pin_mask == BUTTON_PIN) begin
      if (s1_item.raw_pressed) begin
        if (!(s1_item.now_ms < lockout_until) && (phase == PH_IDLE || phase == PH_UP)) begin
          long_done_next           = 1'b0;
          release_pending_next     = 1'b0;
          release_wave_played_next = 1'b0;
          result.haptic_play       = 1'b1;
          result.haptic_wave       = press_wave_id;
          press_wave_played_next   = 1'b1;
          press_wave_end_next      = s1_item.now_ms + {16'd0, waveform_play_ms};
          phase_next               = PH_DOWN;
          phase_since_next         = s1_item.now_ms;
        end
      end else if (phase == PH_PRESSED || phase == PH_DOWN) begin
        if (press_wave_played && !release_wave_played) begin
          release_due_next = (earliest > press_wave_end) ? earliest : press_wave_end;
          if (s1_item.now_ms >= release_due_next) begin
            result.haptic_play       = 1'b1;
            result.haptic_wave       = release_wave_id;
            release_wave_played_next = 1'b1;
          end else begin
            release_pending_next = 1'b1;
          end
          press_wave_played_next = 1'b0;
          lockout_until_next     = s1_item.now_ms + {16'd0, lockout_ms};
        end
        phase_next       = PH_UP;
        phase_since_next = s1_item.now_ms;
      end
    end

    result.pressed = held_next;
    case (phase_next)
      PH_IDLE:    result.fsm_state = FSM_IDLE;
      PH_DOWN:    result.fsm_state = FSM_DOWN;
      PH_PRESSED: result.fsm_state = FSM_PRESSED;
      PH_UP:      result.fsm_state = FSM_UP;
      default:    result.fsm_state = FSM_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ms          <= RST_DEBOUNCE;
      long_press_ms        <= RST_LONG_PRESS;
      single_max_ms        <= RST_SINGLE_MAX;
      release_min_delay_ms <= RST_RELEASE_DELAY;
      lockout_ms           <= RST_LOCKOUT;
      waveform_play_ms     <= RST_WAVE_PLAY;
      press_wave_id        <= RST_PRESS_WAVE;
      release_wave_id      <= RST_RELEASE_WAVE;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_DEBOUNCE:      debounce_ms          <= cfg_data;
        REG_LONG_PRESS:    long_press_ms        <= cfg_data;
        REG_SINGLE_MAX:    single_max_ms        <= cfg_data;
        REG_RELEASE_DELAY: release_min_delay_ms <= cfg_data;
        REG_LOCKOUT:       lockout_ms           <= cfg_data;
        REG_WAVE_PLAY:     waveform_play_ms     <= cfg_data;
        REG_PRESS_WAVE:    press_wave_id        <= cfg_data[7:0];
        REG_RELEASE_WAVE:  release_wave_id      <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase               <= PH_IDLE;
      phase_since         <= '0;
      press_start         <= '0;
      release_due         <= '0;
      lockout_until       <= '0;
      press_wave_end      <= '0;
      held                <= 1'b0;
      long_done           <= 1'b0;
      press_wave_played   <= 1'b0;
      release_pending     <= 1'b0;
      release_wave_played <= 1'b0;
    end else if (s1_fire) begin
      phase               <= phase_next;
      phase_since         <= phase_since_next;
      press_start         <= press_start_next;
      release_due         <= release_due_next;
      lockout_until       <= lockout_until_next;
      press_wave_end      <= press_wave_end_next;
      held                <= held_next;
      long_done           <= long_done_next;
      press_wave_played   <= press_wave_played_next;
      release_pending     <= release_pending_next;
      release_wave_played <= release_wave_played_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_ready) s1_valid <= in_valid;
      if (s1_fire) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) s1_item <= in_data;
    if (s1_fire) out_data <= result;
  end

  a_no_reserved_event: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.event_code != 2'd3)
    else $error("reserved event code");

  a_wave_zero_idle: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.haptic_play |-> out_data.haptic_wave == 8'd0)
    else $error("waveform set without play");

  a_single_released: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.event_code == EV_SINGLE
      |-> !out_data.pressed && out_data.fsm_state == FSM_IDLE)
    else $error("single press while held");

  a_long_held: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.event_code == EV_LONG |-> out_data.pressed)
    else $error("long press while released");

  a_stage_holds: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_advance |=> s1_valid && $stable(s1_item))
    else $error("input stage lost an item");

endmodule

`default_nettype wire
